// File: rtl/core/aacn_pkg.sv
// Shared types and constants for the joystick axis calibrate-and-normalize block.
// Holds the configuration record, register indexes, controller states and the
// command/status records between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package aacn_pkg;

	// Fixed payload widths of the channels and the configuration port.
	localparam int SAMPLE_W   = 12;
	localparam int POS_W      = 8;
	localparam int CENTRE_W   = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam int PCT_FULL  = 100;
	localparam int MAX_GROUP = 16;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CAL_SAMPLES  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAL_TOL_PCT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE_PCT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_HIGH    = 3'd5;

	// Register values after reset.
	localparam logic [4:0]  CAL_SAMPLES_RST  = 5'd20;
	localparam logic [5:0]  CAL_TOL_PCT_RST  = 6'd10;
	localparam logic [4:0]  AVG_COUNT_RST    = 5'd10;
	localparam logic [6:0]  DEADZONE_PCT_RST = 7'd18;
	localparam logic [11:0] INIT_LOW_RST     = 12'd1000;
	localparam logic [11:0] INIT_HIGH_RST    = 12'd2000;

	// Result kinds.
	localparam logic KIND_CAL_DONE = 1'b0;
	localparam logic KIND_POSITION = 1'b1;

	typedef struct packed {
		logic [4:0]  cal_samples;
		logic [5:0]  cal_tolerance_pct;
		logic [4:0]  avg_count;
		logic [6:0]  deadzone_pct;
		logic [11:0] init_low;
		logic [11:0] init_high;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CAL_LOAD,
		ST_CAL_DIV,
		ST_CAL_MUL,
		ST_CAL_CHECK,
		ST_GRP_ACC,
		ST_AVG_DIV,
		ST_TRACK,
		ST_SCALE,
		ST_SCALE_DIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic cal_start;
		logic cal_take_mean;
		logic cal_mul;
		logic cal_check;
		logic grp_acc;
		logic avg_take;
		logic track;
		logic scl_start;
		logic scl_take;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic phase;
		logic div_done;
		logic cal_pass;
		logic cal_last;
		logic group_full;
		logic avg_is_centre;
		logic out_free;
	} status_t;

endpackage

// File: rtl/core/aacn_if.sv
// Valid/ready channel interfaces for the axis block: raw samples in, results out.
// Depends on aacn_pkg for the payload widths.
`timescale 1ns / 1ps

interface aacn_in_if;
	logic                          valid;
	logic                          ready;
	logic [aacn_pkg::SAMPLE_W-1:0] sample;

	modport source(output valid, output sample, input ready);
	modport sink(input valid, input sample, output ready);
endinterface

interface aacn_out_if;
	logic                               valid;
	logic                               ready;
	logic                               kind;
	logic signed [aacn_pkg::POS_W-1:0]  position;
	logic [aacn_pkg::CENTRE_W-1:0]      centre_value;

	modport source(output valid, output kind, output position, output centre_value,
		input ready);
	modport sink(input valid, input kind, input position, input centre_value,
		output ready);
endinterface

// File: rtl/core/aacn_div.sv
// Shared restoring divider of the axis datapath, one quotient bit per cycle.
// Standalone; used by aacn_dp for the running mean, group average and scaling.
`timescale 1ns / 1ps

module aacn_div #(
	parameter int DW = 19,
	parameter int VW = 12
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [VW-1:0] rem_q;
	logic [VW-1:0] den_q;
	logic [DW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(DW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? VW'(trial - {1'b0, den_q}) : VW'(trial);
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: rtl/core/aacn_dp.sv
// Datapath of the axis block: calibration state, group averaging, min/max tracking,
// percent scaling and the output register. Depends on aacn_pkg and aacn_div.
`timescale 1ns / 1ps

module aacn_dp #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  aacn_pkg::cfg_t                      cfg,
	input  aacn_pkg::cmd_t                      cmd,
	output aacn_pkg::status_t                   status,
	input  logic [aacn_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                out_kind,
	output logic signed [aacn_pkg::POS_W-1:0]   out_position,
	output logic [aacn_pkg::CENTRE_W-1:0]       out_centre
);

	import aacn_pkg::*;

	localparam int SB    = SAMPLE_BITS;
	localparam int TW    = (SB > CENTRE_W) ? SB : CENTRE_W;
	localparam int DW    = SB + 7;
	localparam int SUM_W = SB + 4;
	localparam int LW    = SB + 7;
	localparam int HW    = SB + 8;

	logic [SB-1:0]    s_q;
	logic             phase_q;
	logic [4:0]       cal_idx_q;
	logic [SB-1:0]    mean_q;
	logic [SB-1:0]    centre_q;
	logic [TW-1:0]    trk_lo_q;
	logic [TW-1:0]    trk_hi_q;
	logic [SUM_W-1:0] sum_q;
	logic [4:0]       cnt_q;
	logic [LW-1:0]    lhs_q;
	logic [HW-1:0]    hi_q;
	logic [LW-1:0]    lo_q;
	logic [SB-1:0]    avg_q;
	logic             neg_q;
	logic             res_kind_q;
	logic [6:0]       res_mag_q;
	logic             out_valid_q;
	logic             out_kind_q;
	logic [POS_W-1:0] out_pos_q;
	logic [CENTRE_W-1:0] out_centre_q;

	logic [5:0]    cal_next;
	logic          cal_pass;
	logic          cal_last;
	logic [7:0]    tol_hi;
	logic [6:0]    tol_lo;
	logic [4:0]    need;
	logic [4:0]    cnt_next;
	logic          group_full;
	logic [SB-1:0] diff;
	logic [TW-1:0] den;
	logic          div_start;
	logic [DW-1:0] div_num;
	logic [TW-1:0] div_den;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [6:0]    scl_clamped;
	logic [POS_W-1:0] mag_ext;

	// Calibration tolerance bounds and completion test.
	assign tol_hi   = 8'(PCT_FULL) + {2'b00, cfg.cal_tolerance_pct};
	assign tol_lo   = 7'(PCT_FULL) - {1'b0, cfg.cal_tolerance_pct};
	assign cal_next = {1'b0, cal_idx_q} + 6'd1;
	assign cal_last = cal_next >= {1'b0, cfg.cal_samples};
	assign cal_pass = !({1'b0, lhs_q} > hi_q) && !(lhs_q < lo_q);

	// Effective group size is avg_count held within one to sixteen.
	always_comb begin
		if (cfg.avg_count == 5'd0) begin
			need = 5'd1;
		end else if (cfg.avg_count > 5'(MAX_GROUP)) begin
			need = 5'(MAX_GROUP);
		end else begin
			need = cfg.avg_count;
		end
	end

	assign cnt_next   = cnt_q + 5'd1;
	assign group_full = cnt_next >= need;

	assign diff = neg_q ? (centre_q - avg_q) : (avg_q - centre_q);
	assign den  = neg_q ? (TW'(centre_q) - trk_lo_q) : (trk_hi_q - TW'(centre_q));

	// One divider serves the three divisions; the controller never overlaps them.
	assign div_start = cmd.cal_start || (cmd.grp_acc && group_full) || cmd.scl_start;

	always_comb begin
		if (cmd.cal_start) begin
			div_num = DW'(mean_q) * DW'(cal_idx_q) + DW'(s_q);
			div_den = TW'(cal_next);
		end else if (cmd.grp_acc) begin
			div_num = DW'(sum_q) + DW'(s_q);
			div_den = TW'(cnt_next);
		end else begin
			div_num = DW'(diff) * DW'(PCT_FULL);
			div_den = den;
		end
	end

	aacn_div #(
		.DW(DW),
		.VW(TW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_num),
		.divisor (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	always_comb begin
		if (div_quo > DW'(PCT_FULL)) begin
			scl_clamped = 7'(PCT_FULL);
		end else begin
			scl_clamped = div_quo[6:0];
		end
	end

	// Axis state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= 1'b0;
			cal_idx_q <= '0;
			mean_q    <= '0;
			centre_q  <= '0;
			trk_lo_q  <= '0;
			trk_hi_q  <= '0;
			sum_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.cal_take_mean) begin
				mean_q <= SB'(div_quo);
			end
			if (cmd.cal_check) begin
				if (!cal_pass) begin
					cal_idx_q <= '0;
				end else if (cal_last) begin
					centre_q  <= mean_q;
					phase_q   <= 1'b1;
					cal_idx_q <= '0;
					trk_lo_q  <= TW'(cfg.init_low);
					trk_hi_q  <= TW'(cfg.init_high);
					sum_q     <= '0;
					cnt_q     <= '0;
				end else begin
					cal_idx_q <= 5'(cal_next);
				end
			end
			if (cmd.grp_acc) begin
				if (group_full) begin
					sum_q <= '0;
					cnt_q <= '0;
				end else begin
					sum_q <= sum_q + SUM_W'(s_q);
					cnt_q <= cnt_next;
				end
			end
			if (cmd.track) begin
				if (TW'(avg_q) < trk_lo_q) begin
					trk_lo_q <= TW'(avg_q);
				end
				if (TW'(avg_q) > trk_hi_q) begin
					trk_hi_q <= TW'(avg_q);
				end
			end
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (cmd.load_sample) begin
			s_q <= SB'(sample);
		end
		if (cmd.cal_mul) begin
			lhs_q <= LW'(s_q) * LW'(PCT_FULL);
			hi_q  <= HW'(mean_q) * HW'(tol_hi);
			lo_q  <= LW'(mean_q) * LW'(tol_lo);
		end
		if (cmd.avg_take) begin
			avg_q <= SB'(div_quo);
		end
		if (cmd.cal_check) begin
			res_kind_q <= KIND_CAL_DONE;
			res_mag_q  <= '0;
			neg_q      <= 1'b0;
		end
		if (cmd.track) begin
			res_kind_q <= KIND_POSITION;
			res_mag_q  <= '0;
			neg_q      <= avg_q < centre_q;
		end
		if (cmd.scl_take) begin
			res_mag_q <= (scl_clamped < cfg.deadzone_pct) ? 7'd0 : scl_clamped;
		end
	end

	// Output register.
	assign mag_ext = POS_W'(res_mag_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q   <= res_kind_q;
			out_pos_q    <= neg_q ? (~mag_ext + 1'b1) : mag_ext;
			out_centre_q <= CENTRE_W'(centre_q);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_kind     = out_kind_q;
	assign out_position = $signed(out_pos_q);
	assign out_centre   = out_centre_q;

	always_comb begin
		status.phase         = phase_q;
		status.div_done      = div_done;
		status.cal_pass      = cal_pass;
		status.cal_last      = cal_last;
		status.group_full    = group_full;
		status.avg_is_centre = avg_q == centre_q;
		status.out_free      = !out_valid_q || out_ready;
	end

endmodule

// File: rtl/core/aacn_ctrl.sv
// Controller state machine of the axis block; sequences the datapath steps.
// Depends on aacn_pkg for the state, command and status types.
`timescale 1ns / 1ps

module aacn_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  aacn_pkg::status_t status,
	output aacn_pkg::cmd_t    cmd
);

	import aacn_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = status.phase ? ST_GRP_ACC : ST_CAL_LOAD;
				end
			end
			ST_CAL_LOAD: begin
				state_d = ST_CAL_DIV;
			end
			ST_CAL_DIV: begin
				if (status.div_done) begin
					state_d = ST_CAL_MUL;
				end
			end
			ST_CAL_MUL: begin
				state_d = ST_CAL_CHECK;
			end
			ST_CAL_CHECK: begin
				state_d = (status.cal_pass && status.cal_last) ? ST_EMIT : ST_IDLE;
			end
			ST_GRP_ACC: begin
				state_d = status.group_full ? ST_AVG_DIV : ST_IDLE;
			end
			ST_AVG_DIV: begin
				if (status.div_done) begin
					state_d = ST_TRACK;
				end
			end
			ST_TRACK: begin
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				state_d = status.avg_is_centre ? ST_EMIT : ST_SCALE_DIV;
			end
			ST_SCALE_DIV: begin
				if (status.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.load_sample = in_valid;
			end
			ST_CAL_LOAD: begin
				cmd.cal_start = 1'b1;
			end
			ST_CAL_DIV: begin
				cmd.cal_take_mean = status.div_done;
			end
			ST_CAL_MUL: begin
				cmd.cal_mul = 1'b1;
			end
			ST_CAL_CHECK: begin
				cmd.cal_check = 1'b1;
			end
			ST_GRP_ACC: begin
				cmd.grp_acc = 1'b1;
			end
			ST_AVG_DIV: begin
				cmd.avg_take = status.div_done;
			end
			ST_TRACK: begin
				cmd.track = 1'b1;
			end
			ST_SCALE: begin
				cmd.scl_start = !status.avg_is_centre;
			end
			ST_SCALE_DIV: begin
				cmd.scl_take = status.div_done;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/analog_axis_calibrate_normalize.sv
// Joystick axis calibrate-and-normalize block, one sample transaction at a time.
// Calibration sample: load, divide, multiply and check, and emit for the one that
// completes. Position sample: accumulate inside a group; closing a group adds the
// average divide, track and emit, with a scale divide unless average equals centre.
// Reset is asynchronous and active low; it restarts calibration and loads the default
// register values, and no clearing pass follows.
`timescale 1ns / 1ps

module analog_axis_calibrate_normalize #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	aacn_in_if.sink                             samples,
	aacn_out_if.source                          results,
	input  logic                                cfg_we,
	input  logic [aacn_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [aacn_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import aacn_pkg::*;

	// The block runs in two phases. While calibrating, each sample updates a
	// truncating running mean through the divider, and the sample is then checked
	// against the tolerance band around the new mean using three products. A sample
	// outside the band restarts the run; enough samples inside it latch the mean
	// as the centre and produce one calibration-done transaction.
	//
	// Afterwards samples are summed in groups. When a group closes, the divider
	// forms the average, the tracked minimum and maximum are widened, and the
	// divider is used once more to scale the deflection to percent against the
	// tracked extreme on that side. The magnitude is clamped at one hundred and
	// forced to zero inside the deadzone.
	//
	// The output register decouples the result side: a new sample is accepted
	// while a result still waits, and the controller only stalls in its emit step
	// if that earlier result has not been taken by then.

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t status;

	// Configuration registers. Written values are used at once, also by a sample in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cal_samples       <= CAL_SAMPLES_RST;
			cfg_q.cal_tolerance_pct <= CAL_TOL_PCT_RST;
			cfg_q.avg_count         <= AVG_COUNT_RST;
			cfg_q.deadzone_pct      <= DEADZONE_PCT_RST;
			cfg_q.init_low          <= INIT_LOW_RST;
			cfg_q.init_high         <= INIT_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAL_SAMPLES:  cfg_q.cal_samples       <= cfg_data[4:0];
				REG_CAL_TOL_PCT:  cfg_q.cal_tolerance_pct <= cfg_data[5:0];
				REG_AVG_COUNT:    cfg_q.avg_count         <= cfg_data[4:0];
				REG_DEADZONE_PCT: cfg_q.deadzone_pct      <= cfg_data[6:0];
				REG_INIT_LOW:     cfg_q.init_low          <= cfg_data[11:0];
				REG_INIT_HIGH:    cfg_q.init_high         <= cfg_data[11:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The controller owns the input handshake and the order of datapath steps.
	aacn_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(samples.valid),
		.in_ready(samples.ready),
		.status  (status),
		.cmd     (cmd)
	);

	// The datapath holds all axis state, the divider and the output register.
	aacn_dp #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.status      (status),
		.sample      (samples.sample),
		.out_ready   (results.ready),
		.out_valid   (results.valid),
		.out_kind    (results.kind),
		.out_position(results.position),
		.out_centre  (results.centre_value)
	);

endmodule

// File: verif/tb_analog_axis_calibrate_normalize.sv
// Self-checking testbench for analog_axis_calibrate_normalize: directed table, then random phases.
// Depends on aacn_pkg, the aacn_in_if/aacn_out_if channel interfaces and the block itself.
// Each result transaction is compared with a behavioral axis model or a hand-written result.
`timescale 1ns / 1ps

module tb_analog_axis_calibrate_normalize;
	import aacn_pkg::*;

	// Longest stretch without any transaction before the run is declared hung.
	// It covers a closing group sample, the idle draws of both sides and a settle
	// pause with a wide margin.
	localparam int STALL_LIMIT    = 4000;
	// Cycles allowed after the last expected result before touching registers.
	// Calibration samples that do not complete it and samples inside a group produce
	// nothing, so the block may still be busy with one even when nothing is expected.
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_ITEMS   = 1850;
	localparam int DIRECTED_CENTRE = 2500;
	localparam int MAX_REPORTS    = 10;

	typedef struct packed {
		logic                     kind;
		logic signed [POS_W-1:0]  position;
		logic [CENTRE_W-1:0]      centre_value;
	} reading_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_op_t;

	typedef struct packed {
		row_op_t                  op;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    value;
		logic                     typed;
		reading_t                 want;
	} stim_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	aacn_in_if  sample_ch();
	aacn_out_if result_ch();

	analog_axis_calibrate_normalize uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Axis model state: a shadow of the register file plus the calibration,
	// tracking and averaging state of the block.
	cfg_t        axis_regs;
	bit          cal_done;
	int unsigned run_len;
	int unsigned mean_acc;
	int unsigned grp_sum;
	int unsigned grp_len;
	logic [11:0] centre;
	logic [11:0] low_mark;
	logic [11:0] high_mark;

	reading_t  pending_readings[$];
	stim_row_t directed_rows[$];

	int  mismatch_count;
	int  quiet_cycles;
	bit  sender_quiet;
	bit  sink_quiet;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Percentage of a deflection against its span, clamped at full scale and
	// forced to zero inside the deadzone.
	function automatic int unsigned scale_to_pct(input int unsigned num, input int unsigned den);
		int unsigned pct;
		pct = num * PCT_FULL / den;
		if (pct > PCT_FULL)
			pct = PCT_FULL;
		if (pct < axis_regs.deadzone_pct)
			pct = 0;
		return pct;
	endfunction

	// Advances the axis model by one raw sample. Returns 1 when the sample
	// produces a result transaction, which is then written to rd.
	function automatic bit normalize_sample(input logic [11:0] raw, output reading_t rd);
		int unsigned s;
		int unsigned i;
		int unsigned m;
		int unsigned tol;
		int unsigned need;
		int unsigned avg;
		int unsigned c;
		int unsigned hi;
		int unsigned lo;
		int          pos;
		s   = raw;
		rd  = '0;
		pos = 0;
		if (!cal_done) begin
			// The first sample of a run always passes since the mean equals it.
			i = run_len & 32'h1F;
			m = (mean_acc * i + s) / (i + 1);
			mean_acc = m;
			tol = axis_regs.cal_tolerance_pct;
			if (s * PCT_FULL > m * (PCT_FULL + tol) || s * PCT_FULL < m * (PCT_FULL - tol)) begin
				run_len = 0;
				return 1'b0;
			end
			run_len = i + 1;
			// A count of zero, or one lowered below the current run, completes at once.
			if (run_len >= axis_regs.cal_samples) begin
				centre    = m[11:0];
				cal_done  = 1'b1;
				run_len   = 0;
				low_mark  = axis_regs.init_low;
				high_mark = axis_regs.init_high;
				grp_sum   = 0;
				grp_len   = 0;
				rd.kind         = KIND_CAL_DONE;
				rd.centre_value = centre;
				return 1'b1;
			end
			return 1'b0;
		end
		need = axis_regs.avg_count;
		if (need < 1)
			need = 1;
		if (need > MAX_GROUP)
			need = MAX_GROUP;
		grp_sum += s;
		grp_len++;
		if (grp_len < need)
			return 1'b0;
		avg = grp_sum / grp_len;
		grp_sum = 0;
		grp_len = 0;
		if (avg < low_mark)
			low_mark = avg[11:0];
		if (avg > high_mark)
			high_mark = avg[11:0];
		c  = centre;
		hi = high_mark;
		lo = low_mark;
		if (avg > c)
			pos = int'(scale_to_pct(avg - c, hi - c));
		else if (avg < c)
			pos = -int'(scale_to_pct(c - avg, c - lo));
		rd.kind         = KIND_POSITION;
		rd.position     = pos[POS_W-1:0];
		rd.centre_value = centre;
		return 1'b1;
	endfunction

	function automatic int unsigned draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 17);
	endfunction

	function automatic void add_write(input logic [CFG_IDX_W-1:0] idx, input int value);
		stim_row_t r;
		r       = '0;
		r.op    = ROW_WRITE;
		r.idx   = idx;
		r.value = value[CFG_DATA_W-1:0];
		directed_rows.push_back(r);
	endfunction

	function automatic void add_sample(input int value, input bit typed = 1'b0,
		input logic kind = KIND_POSITION, input int pos = 0);
		stim_row_t r;
		r       = '0;
		r.op    = ROW_SAMPLE;
		r.value = value[CFG_DATA_W-1:0];
		r.typed = typed;
		r.want.kind         = kind;
		r.want.position     = pos[POS_W-1:0];
		r.want.centre_value = DIRECTED_CENTRE[CENTRE_W-1:0];
		directed_rows.push_back(r);
	endfunction

	// Register write through the plain write port, mirrored in the model.
	// The enable is then driven low before the task returns, so consecutive writes
	// never assign the enable twice in one time step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		case (idx)
			REG_CAL_SAMPLES:  axis_regs.cal_samples       = value[4:0];
			REG_CAL_TOL_PCT:  axis_regs.cal_tolerance_pct = value[5:0];
			REG_AVG_COUNT:    axis_regs.avg_count         = value[4:0];
			REG_DEADZONE_PCT: axis_regs.deadzone_pct      = value[6:0];
			REG_INIT_LOW:     axis_regs.init_low          = value[11:0];
			REG_INIT_HIGH:    axis_regs.init_high         = value[11:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Stops the sample stream, waits for every expected result and then lets
	// the block finish any sample that produces no result.
	task automatic settle_block();
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Offers one sample transaction. Called and returning at a falling edge.
	// When the idle draw is zero, valid simply stays high for the next item.
	task automatic send_sample(input logic [11:0] raw, input bit typed, input reading_t want);
		int unsigned gap;
		reading_t    rd;
		bit          yields;
		gap = draw_gap(sender_quiet);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid  <= 1'b1;
		sample_ch.sample <= raw;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		yields = normalize_sample(raw, rd);
		// Rows with a hand-written result still advance the model so that later
		// rows are predicted from the right state.
		if (typed)
			pending_readings.push_back(want);
		else if (yields)
			pending_readings.push_back(rd);
		@(negedge clk);
	endtask

	// Hang detection: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("analog_axis_calibrate_normalize regression: fail");
		$finish;
	end

	// Result side. Ready is dropped for a drawn number of cycles per item;
	// half of the time the stall only starts once a result is already waiting,
	// so the block has to hold its output steady.
	initial begin
		int unsigned gap;
		reading_t    got;
		reading_t    exp_rd;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			gap = draw_gap(sink_quiet);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				if ($urandom_range(0, 1) == 1) begin
					@(posedge clk);
					while (!result_ch.valid)
						@(posedge clk);
					@(negedge clk);
				end
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			got.kind         = result_ch.kind;
			got.position     = result_ch.position;
			got.centre_value = result_ch.centre_value;
			if (pending_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result at %0t: kind %0b position %0d centre %0d",
						$realtime, got.kind, got.position, got.centre_value);
			end else begin
				exp_rd = pending_readings.pop_front();
				if (got.kind !== exp_rd.kind || got.position !== exp_rd.position ||
					got.centre_value !== exp_rd.centre_value) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"result mismatch at %0t: expected kind %0b position %0d",
							" centre %0d, got kind %0b position %0d centre %0d"},
							$realtime, exp_rd.kind, exp_rd.position, exp_rd.centre_value,
							got.kind, got.position, got.centre_value);
				end
			end
			@(negedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		int        sent;
		int        span;
		int        style;
		int        target;
		int        pick;
		reading_t  none;
		stim_row_t row;
		bit        after_sample;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		sample_ch.valid  = 1'b0;
		sample_ch.sample = '0;
		result_ch.ready  = 1'b0;
		quiet_cycles     = 0;
		mismatch_count   = 0;
		sender_quiet     = 1'b0;
		sink_quiet       = 1'b0;
		none             = '0;

		// Model state after reset.
		axis_regs.cal_samples       = CAL_SAMPLES_RST;
		axis_regs.cal_tolerance_pct = CAL_TOL_PCT_RST;
		axis_regs.avg_count         = AVG_COUNT_RST;
		axis_regs.deadzone_pct      = DEADZONE_PCT_RST;
		axis_regs.init_low          = INIT_LOW_RST;
		axis_regs.init_high         = INIT_HIGH_RST;
		cal_done  = 1'b0;
		run_len   = 0;
		mean_acc  = 0;
		grp_sum   = 0;
		grp_len   = 0;
		centre    = '0;
		low_mark  = '0;
		high_mark = '0;

		// Calibration with zero tolerance: only an exact match to the mean holds
		// the run, and a full-scale jump after a zero sample restarts it.
		add_write(REG_CAL_SAMPLES, 31);
		add_write(REG_CAL_TOL_PCT, 0);
		add_sample(0);
		add_sample(4095);
		add_sample(4095);
		add_sample(4094);
		add_sample(4095);
		// Tolerance beyond the documented range still holds in its six bits.
		add_write(REG_CAL_TOL_PCT, 63);
		add_sample(1000);
		add_sample(0);
		add_sample(2000);
		add_sample(3000);
		add_write(REG_CAL_TOL_PCT, 50);
		add_sample(DIRECTED_CENTRE);
		// The tracked span starts inverted (low at full scale, high at zero), so
		// the very first averages widen it. Calibration count lowered to zero in
		// the middle of a run closes it on the next consistent sample.
		add_write(REG_INIT_LOW, 0);
		add_write(REG_INIT_HIGH, 4095);
		add_write(REG_INIT_LOW, 4095);
		add_write(REG_INIT_HIGH, 0);
		add_write(REG_AVG_COUNT, 1);
		add_write(REG_DEADZONE_PCT, 0);
		add_write(REG_CAL_SAMPLES, 0);
		add_sample(DIRECTED_CENTRE, 1'b1, KIND_CAL_DONE, 0);
		// Average equal to the centre reads zero; new extremes read full scale.
		add_sample(DIRECTED_CENTRE, 1'b1, KIND_POSITION, 0);
		add_sample(3000, 1'b1, KIND_POSITION, 100);
		add_sample(2000, 1'b1, KIND_POSITION, -100);
		add_sample(2800);
		add_write(REG_DEADZONE_PCT, 100);
		add_sample(4095, 1'b1, KIND_POSITION, 100);
		add_sample(2400);
		// A deadzone above full scale swallows every position.
		add_write(REG_DEADZONE_PCT, 127);
		add_sample(0, 1'b1, KIND_POSITION, 0);
		// An averaging count of zero behaves as one.
		add_write(REG_DEADZONE_PCT, 18);
		add_write(REG_AVG_COUNT, 0);
		add_sample(0, 1'b1, KIND_POSITION, -100);
		// Pairs: the first lands exactly on the deadzone edge, the second inside it.
		add_write(REG_AVG_COUNT, 2);
		add_sample(0);
		add_sample(4095);
		add_sample(2600);
		add_sample(2601);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		after_sample = 1'b0;
		foreach (directed_rows[k]) begin
			row = directed_rows[k];
			if (row.op == ROW_WRITE) begin
				if (after_sample)
					settle_block();
				write_reg(row.idx, int'(row.value));
				after_sample = 1'b0;
			end else begin
				send_sample(row.value, row.typed, row.want);
				after_sample = 1'b1;
			end
		end

		// Random phases. Each one waits for the block to drain (which also
		// leaves partial groups behind, so a lowered count can close them),
		// rewrites the averaging count and deadzone, picks idle behavior for
		// both sides and a sample style around the calibrated centre.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle_block();
			case ($urandom_range(0, 5))
				0: write_reg(REG_AVG_COUNT, 1);
				1: write_reg(REG_AVG_COUNT, MAX_GROUP);
				2: write_reg(REG_AVG_COUNT, 0);
				3: write_reg(REG_AVG_COUNT, 31);
				default: write_reg(REG_AVG_COUNT, $urandom_range(1, MAX_GROUP));
			endcase
			case ($urandom_range(0, 5))
				0: write_reg(REG_DEADZONE_PCT, 0);
				1: write_reg(REG_DEADZONE_PCT, 100);
				2: write_reg(REG_DEADZONE_PCT, 127);
				default: write_reg(REG_DEADZONE_PCT, $urandom_range(0, 60));
			endcase
			// Registers that no longer matter once calibrated; the block must
			// accept them without any visible effect.
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(REG_CAL_SAMPLES, $urandom_range(0, 31));
					1: write_reg(REG_CAL_TOL_PCT, $urandom_range(0, 63));
					2: write_reg(REG_INIT_LOW, $urandom_range(0, 4095));
					default: write_reg(REG_INIT_HIGH, $urandom_range(0, 4095));
				endcase
			end
			sender_quiet = ($urandom_range(0, 3) == 0);
			sink_quiet   = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 2);
			span  = $urandom_range(40, 160);
			repeat (span) begin
				target = int'(centre);
				case (style)
					// Steady axis: the group average often equals the centre.
					1: target = target + int'($urandom_range(0, 2)) - 1;
					// Moderate swing around the centre.
					2: target = target + int'($urandom_range(0, 1600)) - 800;
					default: begin
						pick = $urandom_range(0, 15);
						if (pick < 6)
							target = target + int'($urandom_range(0, 400)) - 200;
						else if (pick == 6)
							target = ($urandom_range(0, 1) == 1) ? 4095 : 0;
						else if (pick > 7)
							target = $urandom_range(0, 4095);
					end
				endcase
				if (target < 0)
					target = 0;
				if (target > 4095)
					target = 4095;
				send_sample(target[11:0], 1'b0, none);
				sent++;
			end
		end

		settle_block();
		if (mismatch_count == 0)
			$display("analog_axis_calibrate_normalize regression: pass");
		else
			$display("analog_axis_calibrate_normalize regression: fail");
		$finish;
	end

endmodule
